/* rtl/epoch_seconds_to_calendar_core_assert.svh */
// Assertion macros shared by the calendar core checkers
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// same-cycle implication
`define ES2C_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("es2cal check failed");

// next-cycle implication
`define ES2C_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("es2cal check failed");

`endif

/* rtl/es2cal_pkg.sv */
// Types, constants and helper functions for the epoch-to-calendar core
`default_nettype none

package es2cal_pkg;

    localparam int OP_W  = 18;  // shared subtractor width
    localparam int REM_W = 17;  // partial remainder width
    localparam int Q_W   = 15;  // day count / quotient shift width

    localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [REM_W-1:0] DAYS_LONG     = 17'd366;
    localparam logic [REM_W-1:0] DAYS_SHORT    = 17'd365;

    localparam logic [7:0] YEAR_FIRST = 8'd70;
    localparam logic [2:0] THURSDAY   = 3'd4;
    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] FEBRUARY   = 4'd1;

    // step counts minus one
    localparam logic [3:0] DAYS_STEPS = 4'd14;
    localparam logic [3:0] HOUR_STEPS = 4'd4;
    localparam logic [3:0] MIN_STEPS  = 4'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOUR,
        ST_MINUTE,
        ST_YEAR,
        ST_MONTH
    } state_t;

    // year given as offset from 1900; 1900 and 2100 are not leap, 2000 is
    function automatic logic year_leap(input logic [7:0] y);
        year_leap = (y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd200);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        case (mon)
            4'd0:    month_len = 5'd31;
            4'd1:    month_len = leap ? 5'd29 : 5'd28;
            4'd2:    month_len = 5'd31;
            4'd3:    month_len = 5'd30;
            4'd4:    month_len = 5'd31;
            4'd5:    month_len = 5'd30;
            4'd6:    month_len = 5'd31;
            4'd7:    month_len = 5'd31;
            4'd8:    month_len = 5'd30;
            4'd9:    month_len = 5'd31;
            4'd10:   month_len = 5'd30;
            4'd11:   month_len = 5'd31;
            default: month_len = 5'd31;
        endcase
    endfunction

    // reduce a value below 14 modulo 7
    function automatic logic [2:0] mod7(input logic [3:0] v);
        logic [3:0] r;
        r    = (v >= 4'd7) ? (v - 4'd7) : v;
        mod7 = r[2:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/es2cal_sub_unit.sv */
// Shared compare-and-subtract unit used by every step of the sequencer
`default_nettype none

module es2cal_sub_unit
(
    input  logic [es2cal_pkg::OP_W-1:0]  a,
    input  logic [es2cal_pkg::REM_W-1:0] b,
    output logic [es2cal_pkg::OP_W-1:0]  diff,
    output logic                         ge
);

    logic [es2cal_pkg::OP_W:0] wide;

    assign wide = {1'b0, a} - {2'b00, b};
    assign diff = wide[es2cal_pkg::OP_W-1:0];
    assign ge   = ~wide[es2cal_pkg::OP_W];

endmodule

`default_nettype wire

/* rtl/epoch_seconds_to_calendar_core.sv */
// Unix seconds to Gregorian UTC calendar time, iterative top level
//
// Converts a 31-bit count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, weekday, day of year, month, day of month and year
// since 1900. All arithmetic runs through one 18-bit compare-and-subtract
// unit: 15 restoring-division steps give the day count (weekday accumulated
// alongside), 5 steps give the hour, 6 the minute and second, then one step
// per whole year since 1970 and one per whole month. in_stall stays high
// from transfer until the result is loaded, which waits while the previous
// result is still held. The result sits in an output register, so the next
// item is taken while it waits.
`default_nettype none

module epoch_seconds_to_calendar_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [30:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [8:0]  year_day,
    output logic [3:0]  month,
    output logic [4:0]  month_day,
    output logic [7:0]  year_since_1900
);

    localparam int OP_W  = es2cal_pkg::OP_W;
    localparam int REM_W = es2cal_pkg::REM_W;
    localparam int Q_W   = es2cal_pkg::Q_W;

    es2cal_pkg::state_t state_reg, state_next;

    logic [3:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0] p_reg, p_next;
    logic [Q_W-1:0]   num_reg, num_next;
    logic [Q_W-1:0]   days_reg, days_next;
    logic [2:0]       wday_reg, wday_next;
    logic [4:0]       hour_w_reg, hour_w_next;
    logic [5:0]       minute_w_reg, minute_w_next;
    logic [5:0]       second_w_reg, second_w_next;
    logic [7:0]       year_reg, year_next;
    logic [8:0]       yday_reg, yday_next;
    logic [3:0]       mon_reg, mon_next;

    logic             out_valid_reg, out_valid_next;
    logic [5:0]       second_reg, second_next;
    logic [5:0]       minute_reg, minute_next;
    logic [4:0]       hour_reg, hour_next;
    logic [2:0]       weekday_reg, weekday_next;
    logic [8:0]       year_day_reg, year_day_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       month_day_reg, month_day_next;
    logic [7:0]       year_out_reg, year_out_next;

    logic             in_xfer;
    logic             can_load;
    logic             leap;
    logic [4:0]       mlen;
    logic             month_end;
    logic [OP_W-1:0]  t_div;
    logic [OP_W-1:0]  op_a;
    logic [REM_W-1:0] op_b;
    logic [OP_W-1:0]  diff;
    logic             ge;
    logic [REM_W-1:0] p_div;
    logic [Q_W-1:0]   q_div;
    logic [2:0]       w_step;

    es2cal_sub_unit u_sub
    (
        .a    (op_a),
        .b    (op_b),
        .diff (diff),
        .ge   (ge)
    );

    assign in_stall  = (state_reg != es2cal_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;
    assign leap      = es2cal_pkg::year_leap(year_reg);
    assign mlen      = es2cal_pkg::month_len(mon_reg, leap);
    assign month_end = (mon_reg == es2cal_pkg::LAST_MONTH) || !ge;

    assign t_div  = {p_reg, num_reg[Q_W-1]};
    assign p_div  = ge ? diff[REM_W-1:0] : t_div[REM_W-1:0];
    assign q_div  = {num_reg[Q_W-2:0], ge};
    assign w_step = es2cal_pkg::mod7({wday_reg, ge});

    // operand select for the shared unit
    always_comb
    begin
        op_a = t_div;
        op_b = '0;
        case (state_reg)
            es2cal_pkg::ST_DAYS:   op_b = es2cal_pkg::SECS_PER_DAY;
            es2cal_pkg::ST_HOUR:   op_b = es2cal_pkg::SECS_PER_HOUR;
            es2cal_pkg::ST_MINUTE: op_b = es2cal_pkg::SECS_PER_MIN;
            es2cal_pkg::ST_YEAR:
            begin
                op_a = {{(OP_W-Q_W){1'b0}}, days_reg};
                op_b = leap ? es2cal_pkg::DAYS_LONG : es2cal_pkg::DAYS_SHORT;
            end
            es2cal_pkg::ST_MONTH:
            begin
                op_a = {{(OP_W-Q_W){1'b0}}, days_reg};
                op_b = {{(REM_W-5){1'b0}}, mlen};
            end
            default:
            begin
                op_a = t_div;
                op_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            es2cal_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = es2cal_pkg::ST_DAYS;
            es2cal_pkg::ST_DAYS:
                if (cnt_reg == 4'd0)
                    state_next = es2cal_pkg::ST_HOUR;
            es2cal_pkg::ST_HOUR:
                if (cnt_reg == 4'd0)
                    state_next = es2cal_pkg::ST_MINUTE;
            es2cal_pkg::ST_MINUTE:
                if (cnt_reg == 4'd0)
                    state_next = es2cal_pkg::ST_YEAR;
            es2cal_pkg::ST_YEAR:
                if (!ge)
                    state_next = es2cal_pkg::ST_MONTH;
            es2cal_pkg::ST_MONTH:
                if (month_end && can_load)
                    state_next = es2cal_pkg::ST_IDLE;
            default:
                state_next = es2cal_pkg::ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        num_next       = num_reg;
        days_next      = days_reg;
        wday_next      = wday_reg;
        hour_w_next    = hour_w_reg;
        minute_w_next  = minute_w_reg;
        second_w_next  = second_w_reg;
        year_next      = year_reg;
        yday_next      = yday_reg;
        mon_next       = mon_reg;
        out_valid_next = out_valid_reg && out_stall;
        second_next    = second_reg;
        minute_next    = minute_reg;
        hour_next      = hour_reg;
        weekday_next   = weekday_reg;
        year_day_next  = year_day_reg;
        month_next     = month_reg;
        month_day_next = month_day_reg;
        year_out_next  = year_out_reg;

        case (state_reg)
            es2cal_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    // top quotient bits are known zero
                    p_next    = {1'b0, epoch_seconds[30:Q_W]};
                    num_next  = epoch_seconds[Q_W-1:0];
                    cnt_next  = es2cal_pkg::DAYS_STEPS;
                    wday_next = 3'd0;
                end
            es2cal_pkg::ST_DAYS:
            begin
                p_next    = p_div;
                num_next  = q_div;
                wday_next = w_step;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    days_next = q_div;
                    wday_next = es2cal_pkg::mod7({1'b0, w_step}
                                                 + {1'b0, es2cal_pkg::THURSDAY});
                    p_next    = {5'b00000, p_div[16:5]};
                    num_next  = {p_div[4:0], 10'd0};
                    cnt_next  = es2cal_pkg::HOUR_STEPS;
                end
            end
            es2cal_pkg::ST_HOUR:
            begin
                p_next   = p_div;
                num_next = q_div;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    hour_w_next = q_div[4:0];
                    p_next      = {11'd0, p_div[11:6]};
                    num_next    = {p_div[5:0], 9'd0};
                    cnt_next    = es2cal_pkg::MIN_STEPS;
                end
            end
            es2cal_pkg::ST_MINUTE:
            begin
                p_next   = p_div;
                num_next = q_div;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    minute_w_next = q_div[5:0];
                    second_w_next = p_div[5:0];
                    year_next     = es2cal_pkg::YEAR_FIRST;
                end
            end
            es2cal_pkg::ST_YEAR:
                if (ge)
                begin
                    days_next = diff[Q_W-1:0];
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    yday_next = days_reg[8:0];
                    mon_next  = 4'd0;
                end
            es2cal_pkg::ST_MONTH:
                if (month_end)
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        second_next    = second_w_reg;
                        minute_next    = minute_w_reg;
                        hour_next      = hour_w_reg;
                        weekday_next   = wday_reg;
                        year_day_next  = yday_reg;
                        month_next     = mon_reg;
                        month_day_next = days_reg[4:0] + 5'd1;
                        year_out_next  = year_reg;
                    end
                end
                else
                begin
                    days_next = diff[Q_W-1:0];
                    mon_next  = mon_reg + 4'd1;
                end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= es2cal_pkg::ST_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        num_reg       <= num_next;
        days_reg      <= days_next;
        wday_reg      <= wday_next;
        hour_w_reg    <= hour_w_next;
        minute_w_reg  <= minute_w_next;
        second_w_reg  <= second_w_next;
        year_reg      <= year_next;
        yday_reg      <= yday_next;
        mon_reg       <= mon_next;
        second_reg    <= second_next;
        minute_reg    <= minute_next;
        hour_reg      <= hour_next;
        weekday_reg   <= weekday_next;
        year_day_reg  <= year_day_next;
        month_reg     <= month_next;
        month_day_reg <= month_day_next;
        year_out_reg  <= year_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign second          = second_reg;
    assign minute          = minute_reg;
    assign hour            = hour_reg;
    assign weekday         = weekday_reg;
    assign year_day        = year_day_reg;
    assign month           = month_reg;
    assign month_day       = month_day_reg;
    assign year_since_1900 = year_out_reg;

endmodule

`default_nettype wire

/* rtl/es2cal_checker.sv */
// Port-level checker for the calendar core, bound to the top level
`default_nettype none

`include "epoch_seconds_to_calendar_core_assert.svh"

module es2cal_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] second,
    input logic [5:0] minute,
    input logic [4:0] hour,
    input logic [2:0] weekday,
    input logic [8:0] year_day,
    input logic [3:0] month,
    input logic [4:0] month_day,
    input logic [7:0] year_since_1900
);

    // a transfer makes the core busy
    `ES2C_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall)

    `ES2C_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(year_day))

    `ES2C_ASSERT_IMP(a_time_range, out_valid, second < 6'd60 && minute < 6'd60 && hour < 5'd24)

    `ES2C_ASSERT_IMP(a_date_range, out_valid, weekday < 3'd7 && month < 4'd12 && month_day != 5'd0 && year_since_1900 >= 8'd70)

endmodule

bind epoch_seconds_to_calendar_core es2cal_checker u_es2cal_checker (.*);

`default_nettype wire
